[rtl/crf_pkg.sv]
// Shared types and constants for the clipped rectangle fill blitter.
// No dependencies; the top level refers to what it uses here by scoped name.
`default_nettype none

package crf_pkg;

  // Command opcodes
  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_TICK  = 1'b1
  } opcode_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 12;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ARENA_HEIGHT = 2'd2;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;
  localparam logic [CFG_W-1:0] ARENA_HEIGHT_RST = 12'd480;

  // Field widths
  localparam int COORD_W = 16;
  localparam int SIZE_W  = 15;
  localparam int GRAY_W  = 8;
  localparam int INDEX_W = 22;
  localparam int PIXEL_W = 24;

endpackage

`default_nettype wire

[rtl/clipped_rectangle_fill_top.sv]
// Clipped rectangle fill blitter, top level.
// Depends on crf_pkg (opcodes, register indexes, field widths).
// Pipeline: a command beat is registered with its clipped geometry (stage A),
// then the state update / pixel result register follows (stage B). Throughput
// is one command per cycle while cmd_stall is low, bounded by the single result
// register. Reset (rst, synchronous) restores the configuration registers to
// their defaults and leaves the block idle with both pipeline stages empty.
`default_nettype none

module clipped_rectangle_fill_top #(
  parameter int FRAC_BITS = 4,
  parameter int MAX_DIM   = 2048
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // configuration write channel
  input  wire logic                             cfg_valid,
  output      logic                             cfg_ready,
  input  wire logic [crf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [crf_pkg::CFG_W-1:0]        cfg_data,
  // command channel
  input  wire logic                             cmd_valid,
  output      logic                             cmd_stall,
  input  wire logic                             opcode,
  input  wire logic signed [crf_pkg::COORD_W-1:0] center_x,
  input  wire logic signed [crf_pkg::COORD_W-1:0] center_y,
  input  wire logic [crf_pkg::SIZE_W-1:0]       rect_width,
  input  wire logic [crf_pkg::SIZE_W-1:0]       rect_height,
  input  wire logic [crf_pkg::GRAY_W-1:0]       gray_level,
  // pixel channel
  output      logic                             pix_valid,
  input  wire logic                             pix_stall,
  output      logic [crf_pkg::INDEX_W-1:0]      pixel_index,
  output      logic [crf_pkg::PIXEL_W-1:0]      pixel_value,
  output      logic                             last_pixel
);

  // Dimension widths follow MAX_DIM: counts hold MAX_DIM itself, coordinates
  // inside the frame stay below it.
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int COL_W = $clog2(MAX_DIM);
  localparam int CFG_W = crf_pkg::CFG_W;
  localparam int CMP_W = (DIM_W > CFG_W) ? DIM_W : CFG_W;
  // Working width for the fixed-point geometry math (covers cx, cy, sizes
  // and arena_height scaled by 2^FRAC_BITS, plus headroom for the clip sums).
  localparam int WW = (DIM_W + FRAC_BITS > 16) ? DIM_W + FRAC_BITS + 3 : 19;
  localparam int RND_HALF = (FRAC_BITS == 0) ? 0 : (1 << (FRAC_BITS - 1));
  localparam int ONE      = 1 << FRAC_BITS;
  localparam int INDEX_W  = crf_pkg::INDEX_W;

  // ------------------------------------------------------------------
  // Configuration registers; the port never pushes back.
  // ------------------------------------------------------------------
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic [CFG_W-1:0] arena_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= crf_pkg::FRAME_WIDTH_RST;
      frame_height <= crf_pkg::FRAME_HEIGHT_RST;
      arena_height <= crf_pkg::ARENA_HEIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      // index 3 is not a register: the beat is dropped
      unique case (cfg_index)
        crf_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        crf_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        crf_pkg::REG_ARENA_HEIGHT: arena_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Registers above MAX_DIM behave as MAX_DIM.
  function automatic logic [DIM_W-1:0] sat_dim(input logic [CFG_W-1:0] v);
    if (CMP_W'(v) > CMP_W'(MAX_DIM)) return DIM_W'(MAX_DIM);
    return DIM_W'(v);
  endfunction

  // Divide by 2^FRAC_BITS, rounding half away from zero.
  function automatic logic signed [WW-1:0] rnd(input logic signed [WW-1:0] v);
    logic signed [WW-1:0] bias;
    bias = WW'(RND_HALF);
    if (v[WW-1] && (FRAC_BITS != 0)) bias = WW'(RND_HALF - 1);
    return (v + bias) >>> FRAC_BITS;
  endfunction

  logic [DIM_W-1:0] fw_sat;
  logic [DIM_W-1:0] fh_sat;
  logic [DIM_W-1:0] ah_sat;

  assign fw_sat = sat_dim(frame_width);
  assign fh_sat = sat_dim(frame_height);
  assign ah_sat = sat_dim(arena_height);

  // ------------------------------------------------------------------
  // Stage A: rectangle geometry from the command fields, registered.
  // ------------------------------------------------------------------
  logic signed [WW-1:0] rw_ext, rh_ext, cx_ext, cy_ext;
  logic signed [WW-1:0] half_w, half_h, ah_fix;
  logic signed [WW-1:0] x_fix, y_fix, x_r, y_r, w_r, h_r;
  logic signed [WW-1:0] x1, y1, w1, h1, w2, h2;
  logic signed [WW-1:0] fw_s, fh_s;
  logic                 geo_empty;

  always_comb begin
    rw_ext = WW'(rect_width);
    rh_ext = WW'(rect_height);
    cx_ext = WW'(center_x);
    cy_ext = WW'(center_y);
    fw_s   = WW'(fw_sat);
    fh_s   = WW'(fh_sat);
    // half sizes in whole pixels, put back on the fixed-point grid
    half_w = ((rw_ext + WW'(ONE)) >>> (FRAC_BITS + 1)) <<< FRAC_BITS;
    half_h = ((rh_ext + WW'(ONE)) >>> (FRAC_BITS + 1)) <<< FRAC_BITS;
    ah_fix = WW'(ah_sat) <<< FRAC_BITS;
    x_fix  = cx_ext - half_w;
    y_fix  = ah_fix - cy_ext - half_h;   // bottom-up Y flipped to top row
    x_r    = rnd(x_fix);
    y_r    = rnd(y_fix);
    w_r    = rnd(rw_ext);
    h_r    = rnd(rh_ext);
    // clip against the left/top edges, then the right/bottom edges
    x1 = x_r[WW-1] ? '0 : x_r;
    w1 = x_r[WW-1] ? w_r + x_r : w_r;
    y1 = y_r[WW-1] ? '0 : y_r;
    h1 = y_r[WW-1] ? h_r + y_r : h_r;
    w2 = (x1 + w1 > fw_s) ? fw_s - x1 : w1;
    h2 = (y1 + h1 > fh_s) ? fh_s - y1 : h1;
    geo_empty = (w2 <= 0) || (h2 <= 0);
  end

  logic              a_valid;
  logic              a_op;
  logic              a_empty;
  logic [COL_W-1:0]  a_left;
  logic [COL_W-1:0]  a_top;
  logic [DIM_W-1:0]  a_w;
  logic [DIM_W-1:0]  a_h;
  logic [crf_pkg::GRAY_W-1:0] a_gray;

  logic cmd_take;
  logic b_go;      // stage B may consume stage A this cycle

  // Stage B moves whenever the result register is empty or being drained.
  assign b_go      = !pix_valid || !pix_stall;
  assign cmd_stall = a_valid && !b_go;
  assign cmd_take  = cmd_valid && !cmd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (cmd_take) begin
      a_valid <= 1'b1;
    end else if (b_go) begin
      a_valid <= 1'b0;
    end
    if (cmd_take) begin
      a_op    <= opcode;
      a_empty <= geo_empty;
      a_gray  <= gray_level;
      a_left  <= geo_empty ? '0 : x1[COL_W-1:0];
      a_top   <= geo_empty ? '0 : y1[COL_W-1:0];
      a_w     <= geo_empty ? '0 : w2[DIM_W-1:0];
      a_h     <= geo_empty ? '0 : h2[DIM_W-1:0];
    end
  end

  // ------------------------------------------------------------------
  // Stage B: drawing state and the pixel result register.
  // ------------------------------------------------------------------
  logic              drawing;
  logic [COL_W-1:0]  left_column;
  logic [DIM_W-1:0]  span_width;
  logic [DIM_W-1:0]  rows_left;
  logic [DIM_W-1:0]  column_count;
  logic [INDEX_W-1:0] row_base;
  logic [crf_pkg::GRAY_W-1:0] fill_gray;

  logic [COL_W+DIM_W-1:0] top_prod;
  logic [DIM_W:0]         cc_inc;
  logic                   row_end;
  logic                   last;
  logic [INDEX_W-1:0]     idx;
  logic                   b_fire;
  logic                   emit;

  assign top_prod = a_top * fw_sat;
  assign cc_inc   = {1'b0, column_count} + 1'b1;
  assign row_end  = cc_inc >= {1'b0, span_width};
  assign last     = row_end && (rows_left <= DIM_W'(1));
  assign idx      = row_base + INDEX_W'(left_column) + INDEX_W'(column_count);
  assign b_fire   = a_valid && b_go;
  assign emit     = b_fire && (a_op == crf_pkg::OP_TICK) && drawing;

  always_ff @(posedge clk) begin
    if (rst) begin
      drawing      <= 1'b0;
      left_column  <= '0;
      span_width   <= '0;
      rows_left    <= '0;
      column_count <= '0;
      row_base     <= '0;
      fill_gray    <= '0;
      pix_valid    <= 1'b0;
    end else begin
      if (b_go) begin
        pix_valid <= emit;
      end
      if (b_fire) begin
        if (a_op == crf_pkg::OP_START) begin
          // a start replaces any rectangle still in progress
          fill_gray    <= a_gray;
          column_count <= '0;
          drawing      <= !a_empty;
          left_column  <= a_left;
          span_width   <= a_w;
          rows_left    <= a_h;
          row_base     <= a_empty ? '0 : INDEX_W'(top_prod);
        end else if (drawing) begin
          if (row_end) begin
            column_count <= '0;
            rows_left    <= last ? '0 : rows_left - 1'b1;
            // stride follows the current frame width at each row change
            row_base     <= row_base + INDEX_W'(fw_sat);
            if (last) begin
              drawing <= 1'b0;
            end
          end else begin
            column_count <= cc_inc[DIM_W-1:0];
          end
        end
      end
    end
  end

  // result payload, loaded only with a pixel
  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_index <= idx;
      pixel_value <= {3{fill_gray}};
      last_pixel  <= last;
    end
  end

endmodule

`default_nettype wire
